// ===== hw/rtl/bsb_pkg.sv =====
// Shared constants and unit operation codes for the B-spline basis evaluator.
package bsb_pkg;

    localparam int DEF_MAX_DEGREE = 20;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int GUARD_BITS     = 8;
    localparam int DIGIT_W        = 4;
    localparam int DEGREE_W       = 5;
    localparam int KNOT_W         = 7;
    localparam int POS_W          = 24;
    localparam logic [DEGREE_W-1:0] RESET_DEGREE = 5'd3;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_MUL_U,
        OP_MUL_W,
        OP_LOAD,
        OP_DIV
    } t_op;

endpackage

// ===== hw/rtl/bsb_unit.sv =====
// Shared multiply/accumulate and radix-16 divide-by-level unit.
module bsb_unit #(
    parameter int FRAC_BITS  = bsb_pkg::DEF_FRAC_BITS,
    parameter int MAX_DEGREE = bsb_pkg::DEF_MAX_DEGREE
) (
    input  logic                                                   i_clk,
    input  bsb_pkg::t_op                                           i_op,
    input  logic [FRAC_BITS+$clog2(MAX_DEGREE+2)-1:0]              i_a,
    input  logic [FRAC_BITS+bsb_pkg::GUARD_BITS+1:0]               i_b,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]                        i_m,
    output logic [FRAC_BITS+bsb_pkg::GUARD_BITS+1:0]               o_quo
);

    localparam int CW   = $clog2(MAX_DEGREE + 2);
    localparam int NW   = $clog2(MAX_DEGREE + 1);
    localparam int UW   = FRAC_BITS + CW;
    localparam int BW   = FRAC_BITS + bsb_pkg::GUARD_BITS + 2;
    localparam int PW   = UW + BW;
    localparam int SW   = PW + 2 - FRAC_BITS;
    localparam int DGW  = bsb_pkg::DIGIT_W;
    localparam int DN   = (SW + DGW - 1) / DGW;
    localparam int NUMW = DN * DGW;
    localparam int XW   = NW + DGW;

    logic [PW-1:0]   r_prod, n_prod;
    logic [PW:0]     r_acc, n_acc;
    logic [NUMW-1:0] r_num, n_num;
    logic [NW-1:0]   r_rem, n_rem;

    logic [PW:0]     rnd;
    logic [PW+1:0]   sum2;
    logic [XW-1:0]   x;
    logic [XW-1:0]   dm;
    logic [XW-1:0]   best_dm;
    logic [DGW-1:0]  digit;

    always_comb begin
        // half of m<<FRAC_BITS, for round to nearest
        rnd  = {{(PW+1-NW){1'b0}}, i_m} << (FRAC_BITS - 1);
        sum2 = {1'b0, r_acc} + {2'b00, r_prod};

        // one quotient digit: largest d with d*m <= {rem, next digit}
        x       = {r_rem, r_num[NUMW-1 -: DGW]};
        digit   = '0;
        best_dm = '0;
        dm      = '0;
        for (int d = 1; d < (1 << DGW); d++) begin
            dm = XW'(d) * {{DGW{1'b0}}, i_m};
            if (x >= dm) begin
                digit   = DGW'(d);
                best_dm = dm;
            end
        end

        n_prod = r_prod;
        n_acc  = r_acc;
        n_num  = r_num;
        n_rem  = r_rem;
        unique case (i_op)
            bsb_pkg::OP_MUL_U: begin
                n_prod = i_a * i_b;
            end
            bsb_pkg::OP_MUL_W: begin
                n_prod = i_a * i_b;
                n_acc  = {1'b0, r_prod} + rnd;
            end
            bsb_pkg::OP_LOAD: begin
                n_num = NUMW'(sum2 >> FRAC_BITS);
                n_rem = '0;
            end
            bsb_pkg::OP_DIV: begin
                n_rem = NW'(x - best_dm);
                n_num = {r_num[NUMW-DGW-1:0], digit};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_num  <= n_num;
        r_rem  <= n_rem;
    end

    assign o_quo = r_num[BW-1:0];

endmodule

// ===== hw/rtl/bspline_basis_eval_core.sv =====
// Top level: uniform B-spline basis evaluator, Cox-de Boor recurrence on a shared unit.
//
// Usage
//   Input transfer: knot_index and position are taken at a rising edge with
//   start high and busy low. busy stays high until the result is out.
//   Result transfer: o_basis_value is valid for exactly one cycle with
//   o_strobe high; the receiver cannot stall, so nothing is ever held back.
//   Configuration: i_cfg_we writes the degree register; write it only while
//   busy is low. Degrees above MAX_DEGREE are treated as MAX_DEGREE.
// Sequence (n = effective degree, DN = ceil((2*FRAC_BITS+clog2(MAX_DEGREE+2)
//   +GUARD_BITS+4-FRAC_BITS)/4) divide steps, 9 at the defaults)
//   Outside the support, or n = 0: the check state sets o_strobe, with no update run.
//   Each of the n*(n+1)/2 updates runs on the one multiplier/divider unit:
//   two products, an accumulate, DN radix-16 digit steps and a write-back.
//   A new start is taken in the same cycle as o_strobe.
// Reset: synchronous, active low; the degree returns to 3 and any item in
//   flight is dropped without a result.
module bspline_basis_eval_core #(
    parameter int MAX_DEGREE = bsb_pkg::DEF_MAX_DEGREE,
    parameter int FRAC_BITS  = bsb_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [bsb_pkg::KNOT_W-1:0]    i_knot_index,
    input  logic signed [bsb_pkg::POS_W-1:0]     i_position,
    input  logic                                 i_cfg_we,
    input  logic [bsb_pkg::DEGREE_W-1:0]         i_cfg_wdata,
    output logic                                 o_strobe,
    output logic [FRAC_BITS:0]                   o_basis_value
);

    localparam int CW   = $clog2(MAX_DEGREE + 2);   // index / count width
    localparam int NW   = $clog2(MAX_DEGREE + 1);   // degree / level width
    localparam int UW   = FRAC_BITS + CW;           // weights u, w
    localparam int GB   = bsb_pkg::GUARD_BITS;
    localparam int BW   = FRAC_BITS + GB + 2;       // recurrence values
    localparam int PW   = UW + BW;
    localparam int SW   = PW + 2 - FRAC_BITS;
    localparam int DN   = (SW + bsb_pkg::DIGIT_W - 1) / bsb_pkg::DIGIT_W;
    localparam int DCW  = (DN > 1) ? $clog2(DN) : 1;
    localparam int DW   = bsb_pkg::DEGREE_W;
    localparam int KW   = bsb_pkg::KNOT_W;
    localparam int PSW  = bsb_pkg::POS_W;
    localparam int TW   = ((PSW > KW + FRAC_BITS) ? PSW : KW + FRAC_BITS) + 1;
    localparam int DEPTH = MAX_DEGREE + 2;

    localparam logic [BW-1:0]        ONE_B   = BW'(1) << (FRAC_BITS + GB);
    localparam logic [FRAC_BITS:0]   ONE_OUT = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ISSUE1,
        S_MUL0,
        S_MUL1,
        S_LOAD,
        S_DIV,
        S_WR
    } t_state;

    t_state                r_state, n_state;
    logic [DW-1:0]         r_degree, n_degree;
    logic signed [KW-1:0]  r_knot, n_knot;
    logic signed [PSW-1:0] r_pos, n_pos;
    logic [UW-1:0]         r_t, n_t;
    logic [CW-1:0]         r_seg, n_seg;
    logic [NW-1:0]         r_lvl, n_lvl;
    logic [CW-1:0]         r_j, n_j;
    logic [DCW-1:0]        r_dc, n_dc;
    logic [BW-1:0]         r_b0, n_b0;
    logic [BW-1:0]         r_b1, n_b1;
    logic                  r_strobe, n_strobe;
    logic [FRAC_BITS:0]    r_basis, n_basis;

    // b[] store; level 1 reads come from the indicator, so no clearing needed
    logic [BW-1:0]         r_mem [DEPTH];
    logic [BW-1:0]         r_rd_mem;
    logic [CW-1:0]         r_rd_addr;
    logic                  r_rd_lvl1;

    logic [CW-1:0]         ra;
    logic                  rlvl1;
    logic                  mem_we;
    logic [BW-1:0]         rd_val;

    bsb_pkg::t_op          op;
    logic [UW-1:0]         op_a;
    logic [BW-1:0]         op_b;
    logic [BW-1:0]         quo;

    logic [NW-1:0]         deg_n;
    logic signed [TW-1:0]  px, kx, t_full;
    logic [TW-1:0]         lim;
    logic                  outside;
    logic [UW:0]           u_raw, w_raw;
    logic [UW-1:0]         u_term, w_term;
    logic [CW-1:0]         jm1;
    logic                  lvl_is1, last_j, last_lvl;
    logic [BW:0]           rq;
    logic [FRAC_BITS+2:0]  rsh;
    logic [FRAC_BITS:0]    final_val;

    bsb_unit #(
        .FRAC_BITS  (FRAC_BITS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_unit (
        .i_clk (i_clk),
        .i_op  (op),
        .i_a   (op_a),
        .i_b   (op_b),
        .i_m   (r_lvl),
        .o_quo (quo)
    );

    // datapath terms
    always_comb begin
        deg_n = (r_degree > DW'(MAX_DEGREE)) ? NW'(MAX_DEGREE) : r_degree[NW-1:0];

        // t = x - i, exact; support is [0, (n+1)*one)
        px      = TW'(r_pos);
        kx      = TW'(r_knot);
        t_full  = px - (kx <<< FRAC_BITS);
        lim     = TW'({CW'(deg_n) + CW'(1), {FRAC_BITS{1'b0}}});
        outside = t_full[TW-1] | ($unsigned(t_full) >= lim);

        // u = t - j, w = (j+m+1) - t; a non-positive weight contributes nothing
        u_raw  = {1'b0, r_t} - {1'b0, r_j, {FRAC_BITS{1'b0}}};
        u_term = (!u_raw[UW] && (u_raw != '0)) ? u_raw[UW-1:0] : '0;
        jm1    = r_j + CW'(r_lvl) + CW'(1);
        w_raw  = {1'b0, jm1, {FRAC_BITS{1'b0}}} - {1'b0, r_t};
        w_term = (!w_raw[UW] && (w_raw != '0)) ? w_raw[UW-1:0] : '0;

        lvl_is1  = (r_lvl == NW'(1));
        last_j   = (r_j == CW'(deg_n - r_lvl));
        last_lvl = (r_lvl == deg_n);

        rd_val = r_rd_lvl1 ? ((r_rd_addr == r_seg) ? ONE_B : '0) : r_rd_mem;

        // drop guard bits with round half up, clamp at 1.0
        rq        = {1'b0, quo} + (BW+1)'(1 << (GB - 1));
        rsh       = rq[BW:GB];
        final_val = (rsh > (FRAC_BITS+3)'(ONE_OUT)) ? ONE_OUT : rsh[FRAC_BITS:0];
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_degree = r_degree;
        n_knot   = r_knot;
        n_pos    = r_pos;
        n_t      = r_t;
        n_seg    = r_seg;
        n_lvl    = r_lvl;
        n_j      = r_j;
        n_dc     = r_dc;
        n_b0     = r_b0;
        n_b1     = r_b1;
        n_strobe = 1'b0;
        n_basis  = r_basis;
        op       = bsb_pkg::OP_IDLE;
        op_a     = '0;
        op_b     = '0;
        ra       = '0;
        rlvl1    = 1'b0;
        mem_we   = 1'b0;

        if (i_cfg_we) begin
            n_degree = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_knot  = i_knot_index;
                    n_pos   = i_position;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_t   = t_full[UW-1:0];
                n_seg = t_full[UW-1:FRAC_BITS];
                n_lvl = NW'(1);
                n_j   = '0;
                if (outside) begin
                    n_basis  = '0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (deg_n == '0) begin
                    n_basis  = ONE_OUT;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    ra      = '0;
                    rlvl1   = 1'b1;
                    n_state = S_ISSUE1;
                end
            end
            S_ISSUE1: begin
                // level start: old b[0] arrives, fetch b[1]
                n_b0    = rd_val;
                ra      = r_j + CW'(1);
                rlvl1   = lvl_is1;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                n_b1    = rd_val;
                op      = bsb_pkg::OP_MUL_U;
                op_a    = u_term;
                op_b    = r_b0;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                op      = bsb_pkg::OP_MUL_W;
                op_a    = w_term;
                op_b    = r_b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                op      = bsb_pkg::OP_LOAD;
                n_dc    = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                op   = bsb_pkg::OP_DIV;
                n_dc = r_dc + DCW'(1);
                if (r_dc == DCW'(DN - 1)) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                mem_we = 1'b1;
                if (!last_j) begin
                    // old b[j+1] becomes the next left operand
                    n_j     = r_j + CW'(1);
                    n_b0    = r_b1;
                    ra      = r_j + CW'(2);
                    rlvl1   = lvl_is1;
                    n_state = S_MUL0;
                end else if (!last_lvl) begin
                    n_lvl   = r_lvl + NW'(1);
                    n_j     = '0;
                    ra      = '0;
                    rlvl1   = 1'b0;
                    n_state = S_ISSUE1;
                end else begin
                    n_basis  = final_val;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_knot  <= n_knot;
        r_pos   <= n_pos;
        r_t     <= n_t;
        r_seg   <= n_seg;
        r_b0    <= n_b0;
        r_b1    <= n_b1;
        r_basis <= n_basis;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_degree <= bsb_pkg::RESET_DEGREE;
            r_strobe <= 1'b0;
            r_lvl    <= '0;
            r_j      <= '0;
            r_dc     <= '0;
        end else begin
            r_state  <= n_state;
            r_degree <= n_degree;
            r_strobe <= n_strobe;
            r_lvl    <= n_lvl;
            r_j      <= n_j;
            r_dc     <= n_dc;
        end
    end

    // b[] store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_j] <= quo;
        end
        r_rd_mem  <= r_mem[ra];
        r_rd_addr <= ra;
        r_rd_lvl1 <= rlvl1;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_basis_value = r_basis;

    // busy drops only together with a result
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    // a result never exceeds 1.0
    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_basis_value <= ONE_OUT))
        else $error("basis value above 1.0");

    // one result per item: no two strobes back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe repeated");

    // an accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but block not busy");

endmodule
